// ----- src/periodic_soft_timer_table_defines.svh -----
// ----------------------------------------------------------------------------
// Periodic soft timer table: assertion macros
// Shared property macros for the port checker.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_SOFT_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_SOFT_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define PST_ASSERT_SAME(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pst assertion failed");

// next-cycle implication
`define PST_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pst assertion failed");

`endif

// ----- src/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Types and constants of the periodic soft timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

   localparam logic [15:0] INACTIVE      = 16'hFFFF;
   localparam int          MAX_RESULTS   = 16;
   localparam int          N_BITS        = $clog2(MAX_RESULTS + 1);
   localparam int          REQ_DATA_BITS = 24;
   localparam int          REQ_USER_BITS = 3;
   localparam int          RSP_DATA_BITS = 8;
   localparam int          RSP_USER_BITS = 3;

   typedef enum logic [2:0] {
      FUNC_ACTIVATE   = 3'd0,
      FUNC_CANCEL     = 3'd1,
      FUNC_CANCEL_ALL = 3'd2,
      FUNC_TICK       = 3'd3,
      FUNC_SERVICE    = 3'd4
   } pst_func_type;

   typedef enum logic [1:0] {
      STS_REARM = 2'd0,
      STS_NEW   = 2'd1,
      STS_FULL  = 2'd2,
      STS_DONE  = 2'd3
   } pst_status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_COMMIT,
      STATE_REPLY
   } pst_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
      logic reply;
   } pst_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic is_activate;
      logic out_free;
   } pst_stat_type;

endpackage

`default_nettype wire

// ----- src/pst_ram.sv -----
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/pst_ctrl.sv -----
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer: accept an operation, run the slot scan, commit (activate only), send the reply.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire pst_pkg::pst_stat_type stat,
   output pst_pkg::pst_cmd_type       cmd
);

   pst_pkg::pst_state_type state_ff;
   pst_pkg::pst_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pst_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pst_pkg::STATE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = pst_pkg::STATE_SCAN;
            end
         end
         pst_pkg::STATE_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = stat.is_activate ? pst_pkg::STATE_COMMIT : pst_pkg::STATE_REPLY;
            end
         end
         pst_pkg::STATE_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = pst_pkg::STATE_REPLY;
         end
         pst_pkg::STATE_REPLY: begin
            cmd.reply = 1'b1;
            if (stat.out_free) begin
               state_in = pst_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = pst_pkg::STATE_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/pst_dp.sv -----
// ----------------------------------------------------------------------------
// pst_dp
// Slot datapath: slot RAM with valid bits, slot-serial read-modify-write scan,
// activate search, due-event buffer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_dp #(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pst_pkg::pst_cmd_type                cmd,
   output pst_pkg::pst_stat_type                    stat,
   input  wire logic [pst_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  wire logic [pst_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [pst_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic      [pst_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int XW = (ID_BITS > 8) ? ID_BITS : 8;
   localparam int DW = 32 + ID_BITS;
   localparam int NB = pst_pkg::N_BITS;

   // operation registers
   pst_pkg::pst_func_type func_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [15:0]           iv_ff;
   logic [ID_BITS-1:0]    id_in;
   logic [15:0]           iv_in;
   logic [XW-1:0]         req_id_x;

   // scan control
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  pv_ff, pv_in;
   logic [IW-1:0]         pidx_ff, pidx_in;
   logic [NB-1:0]         n_ff, n_in;
   logic                  pend_v_ff, pend_v_in;
   logic [ID_BITS-1:0]    pend_id_ff, pend_id_in;
   logic                  hit_ff, hit_in;
   logic [IW-1:0]         hit_idx_ff, hit_idx_in;
   logic                  free_ff, free_in;
   logic [IW-1:0]         free_idx_ff, free_idx_in;
   logic [SLOTS-1:0]      vld_ff, vld_in;

   // result register
   logic                  out_v_ff, out_v_in;
   logic [1:0]            out_st_ff, out_st_in;
   logic                  out_fired_ff, out_fired_in;
   logic [7:0]            out_id_ff, out_id_in;
   logic                  out_last_ff, out_last_in;

   // slot access
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [DW-1:0]         wr_data;
   logic                  rd_en;
   logic [DW-1:0]         ram_q;
   logic [DW-1:0]         q;
   logic [15:0]           rem;
   logic [15:0]           rel;
   logic [ID_BITS-1:0]    own;
   logic [XW-1:0]         pend_x;
   logic                  out_free;
   logic                  due;
   logic                  stall;
   logic                  adv;
   logic                  proc;
   logic                  emit;
   logic                  reply_load;

   pst_ram #(
      .WIDTH (DW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      req_id_x = XW'(req_tdata[7:0]);
      id_in    = req_id_x[ID_BITS-1:0];
      iv_in    = req_tdata[23:8];
      if (iv_in == 16'd0) begin
         iv_in = 16'd1;
      end else if (iv_in == pst_pkg::INACTIVE) begin
         iv_in = pst_pkg::INACTIVE - 16'd1;
      end
   end

   always_comb begin
      q        = vld_ff[pidx_ff] ? ram_q : {pst_pkg::INACTIVE, 16'd0, ID_BITS'(0)};
      rem      = q[DW-1 -: 16];
      rel      = q[ID_BITS +: 16];
      own      = q[ID_BITS-1:0];
      pend_x   = XW'(pend_id_ff);
      out_free = !out_v_ff || rsp_tready;
      due      = (rem == 16'd0) && (n_ff < NB'(pst_pkg::MAX_RESULTS));
      stall    = (func_ff == pst_pkg::FUNC_SERVICE) && pv_ff && due && pend_v_ff && !out_free;
      adv      = cmd.scan && !stall;
      rd_en    = adv && (cnt_ff != CW'(SLOTS));
      proc     = adv && pv_ff;
      emit     = proc && (func_ff == pst_pkg::FUNC_SERVICE) && due && pend_v_ff;
      reply_load = cmd.reply && out_free;
   end

   always_comb begin
      cnt_in      = cnt_ff;
      pv_in       = pv_ff;
      pidx_in     = pidx_ff;
      n_in        = n_ff;
      pend_v_in   = pend_v_ff;
      pend_id_in  = pend_id_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      vld_in      = vld_ff;
      wr_en       = 1'b0;
      wr_addr     = pidx_ff;
      wr_data     = q;

      if (cmd.load) begin
         cnt_in    = '0;
         pv_in     = 1'b0;
         n_in      = '0;
         pend_v_in = 1'b0;
         hit_in    = 1'b0;
         free_in   = 1'b0;
      end

      if (adv) begin
         pv_in = rd_en;
         if (rd_en) begin
            cnt_in  = cnt_ff + CW'(1);
            pidx_in = cnt_ff[IW-1:0];
         end
      end

      if (proc) begin
         case (func_ff)
            pst_pkg::FUNC_ACTIVATE: begin
               if (!hit_ff && (rem != pst_pkg::INACTIVE) && (own == id_ff)) begin
                  hit_in     = 1'b1;
                  hit_idx_in = pidx_ff;
               end
               if (!free_ff && (rem == pst_pkg::INACTIVE)) begin
                  free_in     = 1'b1;
                  free_idx_in = pidx_ff;
               end
            end
            pst_pkg::FUNC_CANCEL: begin
               if (own == id_ff) begin
                  wr_en   = 1'b1;
                  wr_data = {pst_pkg::INACTIVE, rel, own};
               end
            end
            pst_pkg::FUNC_CANCEL_ALL: begin
               wr_en   = 1'b1;
               wr_data = {pst_pkg::INACTIVE, rel, ID_BITS'(0)};
            end
            pst_pkg::FUNC_TICK: begin
               if ((rem != pst_pkg::INACTIVE) && (rem != 16'd0)) begin
                  wr_en   = 1'b1;
                  wr_data = {rem - 16'd1, rel, own};
               end
            end
            pst_pkg::FUNC_SERVICE: begin
               if (due) begin
                  wr_en      = 1'b1;
                  wr_data    = {rel, rel, own};
                  n_in       = n_ff + NB'(1);
                  pend_v_in  = 1'b1;
                  pend_id_in = own;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.commit && (hit_ff || free_ff)) begin
         wr_en   = 1'b1;
         wr_addr = hit_ff ? hit_idx_ff : free_idx_ff;
         wr_data = {iv_ff, iv_ff, id_ff};
      end

      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      out_v_in     = out_v_ff;
      out_st_in    = out_st_ff;
      out_fired_in = out_fired_ff;
      out_id_in    = out_id_ff;
      out_last_in  = out_last_ff;
      if (rsp_tready) begin
         out_v_in = 1'b0;
      end
      if (emit) begin
         out_v_in     = 1'b1;
         out_st_in    = pst_pkg::STS_DONE;
         out_fired_in = 1'b1;
         out_id_in    = pend_x[7:0];
         out_last_in  = 1'b0;
      end else if (reply_load) begin
         out_v_in     = 1'b1;
         out_st_in    = pst_pkg::STS_DONE;
         out_fired_in = 1'b0;
         out_id_in    = 8'd0;
         out_last_in  = 1'b1;
         if (func_ff == pst_pkg::FUNC_ACTIVATE) begin
            out_st_in = hit_ff ? pst_pkg::STS_REARM :
                        free_ff ? pst_pkg::STS_NEW : pst_pkg::STS_FULL;
         end else if ((func_ff == pst_pkg::FUNC_SERVICE) && pend_v_ff) begin
            out_fired_in = 1'b1;
            out_id_in    = pend_x[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         pv_ff     <= 1'b0;
         n_ff      <= '0;
         pend_v_ff <= 1'b0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
         vld_ff    <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         pv_ff     <= pv_in;
         n_ff      <= n_in;
         pend_v_ff <= pend_v_in;
         hit_ff    <= hit_in;
         free_ff   <= free_in;
         vld_ff    <= vld_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= pst_pkg::pst_func_type'(req_tuser);
         id_ff   <= id_in;
         iv_ff   <= iv_in;
      end
      pidx_ff      <= pidx_in;
      pend_id_ff   <= pend_id_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      out_st_ff    <= out_st_in;
      out_fired_ff <= out_fired_in;
      out_id_ff    <= out_id_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      stat.scan_done   = (cnt_ff == CW'(SLOTS)) && !pv_ff;
      stat.is_activate = (func_ff == pst_pkg::FUNC_ACTIVATE);
      stat.out_free    = out_free;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_id_ff;
   assign rsp_tuser  = {out_fired_ff, out_st_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ----- src/periodic_soft_timer_table.sv -----
// Each operation is accepted, scanned slot by slot, committed (activate only) and
// replied to before the next is taken, as the slot-serial read-modify-write scan
// over the slot RAM serves one at a time; scan and reply wait when rsp stalls.
// Service results leave in scan or reply, one per due slot, at most 16 per operation.
// Reset: synchronous, active high; clears the slot valid bits so every slot reads
// inactive at once, with no clearing pass.
// ----------------------------------------------------------------------------
// periodic_soft_timer_table
// Table of periodic timer slots: activate, cancel, cancel-all, tick, service.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_soft_timer_table #(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [7:0] event_id, [23:8] interval
   input  wire logic [pst_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [2:0] func
   input  wire logic [pst_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] fired_id
   output logic      [pst_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // [1:0] status, [2] fired
   output logic      [pst_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   output logic                                     rsp_tlast
);

   pst_pkg::pst_cmd_type  cmd;
   pst_pkg::pst_stat_type stat;

   pst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pst_dp #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- src/pst_chk.sv -----
// ----------------------------------------------------------------------------
// pst_chk
// Port checker for the result channel of the periodic soft timer table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_soft_timer_table_defines.svh"

module pst_chk (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [pst_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input wire logic [pst_pkg::RSP_USER_BITS-1:0]  rsp_tuser,
   input wire logic                               rsp_tlast
);

   logic rsp_wait;
   logic rsp_fired;
   logic rsp_done;
   logic [pst_pkg::RSP_DATA_BITS+pst_pkg::RSP_USER_BITS:0] rsp_word;

   assign rsp_wait  = rsp_tvalid && !rsp_tready;
   assign rsp_fired = rsp_tuser[2];
   assign rsp_done  = (rsp_tuser[1:0] == pst_pkg::STS_DONE);
   assign rsp_word  = {rsp_tlast, rsp_tuser, rsp_tdata};

   `PST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_word))
   `PST_ASSERT_SAME(a_idle_id_zero, clock, reset, rsp_tvalid && !rsp_fired, rsp_tdata == 8'd0)
   `PST_ASSERT_SAME(a_fired_done, clock, reset, rsp_tvalid && rsp_fired, rsp_done)
   `PST_ASSERT_SAME(a_mid_fired, clock, reset, rsp_tvalid && !rsp_tlast, rsp_fired)

endmodule

bind periodic_soft_timer_table pst_chk u_pst_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- bench/tb_periodic_soft_timer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_soft_timer_table
// Drives activate, cancel, cancel-all, tick, service and reserved operations
// into the timer table: a short directed table first, then random operation
// sequences built around a small pool of event ids. A shadow copy of the slot
// table predicts the results, but for typed directed rows that give their own;
// each result transfer is checked field by field against the oldest prediction,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb_periodic_soft_timer_table;
   import pst_pkg::*;

   localparam int          SLOT_COUNT    = 16;
   localparam int          RANDOM_ITEMS  = 335;
   localparam int          WATCHDOG_MAX  = 2000;
   localparam int          DRAIN_CYCLES  = 2 * (SLOT_COUNT + 4);
   localparam int          DIRECTED_ROWS = 25;
   localparam int          ID_POOL_SIZE  = 6;
   localparam int          MAX_REPORTS   = 100;
   localparam logic [2:0]  FUNC_RSVD_LO  = 3'd5;
   localparam logic [2:0]  FUNC_RSVD_HI  = 3'd7;

   typedef struct packed {
      pst_status_type status;
      logic           fired;
      logic [7:0]     fired_id;
      logic           last;
   } timer_result_t;

   typedef struct packed {
      logic [2:0]     func;
      logic [7:0]     event_id;
      logic [15:0]    interval;
      logic           typed;
      pst_status_type status;
   } op_row_t;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // [7:0] event_id, [23:8] interval
   logic [REQ_DATA_BITS-1:0]   req_tdata  = '0;
   // [2:0] func
   logic [REQ_USER_BITS-1:0]   req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // [7:0] fired_id
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   // [1:0] status, [2] fired
   logic [RSP_USER_BITS-1:0]   rsp_tuser;
   logic                       rsp_tlast;

   logic [15:0]    shadow_remaining [SLOT_COUNT];
   logic [15:0]    shadow_reload    [SLOT_COUNT];
   logic [7:0]     shadow_owner     [SLOT_COUNT];
   timer_result_t  step_results[$];
   timer_result_t  pending_results[$];
   op_row_t        directed_ops [DIRECTED_ROWS];
   logic [7:0]     id_pool [ID_POOL_SIZE];

   int  error_count   = 0;
   int  items_sent    = 0;
   int  results_seen  = 0;
   int  fired_seen    = 0;
   int  rearm_seen    = 0;
   int  full_seen     = 0;
   int  idle_cycles   = 0;
   bit  tx_calm       = 1'b0;
   bit  rx_calm       = 1'b0;
   int  rx_stall_left = 0;
   int  rx_calm_left  = 0;

   periodic_soft_timer_table #(
      .SLOTS   (SLOT_COUNT),
      .ID_BITS (8)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   task automatic reset_shadow_table();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_remaining[i] = INACTIVE;
         shadow_reload[i]    = 16'd0;
         shadow_owner[i]     = 8'd0;
      end
   endtask

   // update the shadow table for one operation and collect its results
   task automatic apply_timer_op(input logic [2:0] func, input logic [7:0] event_id,
                                 input logic [15:0] interval);
      timer_result_t  res;
      pst_status_type status;
      logic [15:0]    period;
      bit             placed;
      int             n;
      step_results.delete();
      status = STS_DONE;
      placed = 1'b0;
      n      = 0;
      case (func)
         FUNC_ACTIVATE: begin
            period = (interval == 16'd0) ? 16'd1 :
                     (interval == INACTIVE) ? INACTIVE - 16'd1 : interval;
            status = STS_FULL;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!placed && shadow_remaining[i] != INACTIVE &&
                   shadow_owner[i] == event_id) begin
                  shadow_remaining[i] = period;
                  shadow_reload[i]    = period;
                  status              = STS_REARM;
                  placed              = 1'b1;
               end
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!placed && shadow_remaining[i] == INACTIVE) begin
                  shadow_remaining[i] = period;
                  shadow_reload[i]    = period;
                  shadow_owner[i]     = event_id;
                  status              = STS_NEW;
                  placed              = 1'b1;
               end
            end
         end
         FUNC_CANCEL: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (shadow_owner[i] == event_id) shadow_remaining[i] = INACTIVE;
         end
         FUNC_CANCEL_ALL: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               shadow_remaining[i] = INACTIVE;
               shadow_owner[i]     = 8'd0;
            end
         end
         FUNC_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (shadow_remaining[i] != INACTIVE && shadow_remaining[i] != 16'd0)
                  shadow_remaining[i] = shadow_remaining[i] - 16'd1;
         end
         FUNC_SERVICE: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (n < MAX_RESULTS && shadow_remaining[i] == 16'd0) begin
                  shadow_remaining[i] = shadow_reload[i];
                  res.status   = STS_DONE;
                  res.fired    = 1'b1;
                  res.fired_id = shadow_owner[i];
                  res.last     = 1'b0;
                  step_results.push_back(res);
                  n++;
               end
            end
            if (n > 0) begin
               res      = step_results.pop_back();
               res.last = 1'b1;
               step_results.push_back(res);
            end
         end
         default: ;
      endcase
      if (step_results.size() == 0) begin
         res.status   = status;
         res.fired    = 1'b0;
         res.fired_id = 8'd0;
         res.last     = 1'b1;
         step_results.push_back(res);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (tx_calm || r < 10) return 0;
      if (r < 17) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] pick_interval();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 16'd0;
      if (r == 1) return INACTIVE;
      if (r == 2) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(1, 5));
   endfunction

   function automatic logic [7:0] pick_id();
      if ($urandom_range(0, 3) != 0) return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic issue_op(input logic [2:0] func, input logic [7:0] event_id,
                           input logic [15:0] interval, input logic typed = 1'b0,
                           input pst_status_type status = STS_DONE);
      int            gap;
      timer_result_t res;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {interval, event_id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_timer_op(func, event_id, interval);
      if (typed) begin
         res.status   = status;
         res.fired    = 1'b0;
         res.fired_id = 8'd0;
         res.last     = 1'b1;
         pending_results.push_back(res);
      end else begin
         foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      if (rx_calm_left == 0) begin
         rx_calm_left <= $urandom_range(50, 300);
         rx_calm      <= ($urandom_range(0, 3) == 0);
      end else begin
         rx_calm_left <= rx_calm_left - 1;
      end
      if (rx_stall_left != 0) begin
         rsp_tready    <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
         rsp_tready    <= 1'b0;
         rx_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
                                                         $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      timer_result_t want;
      timer_result_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = pst_status_type'(rsp_tuser[1:0]);
         got.fired    = rsp_tuser[2];
         got.fired_id = rsp_tdata;
         got.last     = rsp_tlast;
         results_seen++;
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: result with none expected: status=%0d fired=%0b id=%02h last=%0b",
                        $time, got.status, got.fired, got.fired_id, got.last);
         end else begin
            want = pending_results.pop_front();
            if (want.fired) fired_seen++;
            if (want.status == STS_REARM) rearm_seen++;
            if (want.status == STS_FULL) full_seen++;
            if (got != want) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"%0t: result mismatch: expected status=%0d fired=%0b id=%02h ",
                            "last=%0b, got status=%0d fired=%0b id=%02h last=%0b"},
                           $time, want.status, want.fired, want.fired_id, want.last,
                           got.status, got.fired, got.fired_id, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] base_id;
      int         kind;
      int         count;

      directed_ops = '{
         '{FUNC_SERVICE,    8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_TICK,       8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_CANCEL,     8'h5A, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_CANCEL_ALL, 8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_RSVD_LO,    8'hFF, 16'hFFFF, 1'b1, STS_DONE},
         '{FUNC_RSVD_HI,    8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_ACTIVATE,   8'h00, 16'h0000, 1'b1, STS_NEW},
         '{FUNC_ACTIVATE,   8'hFF, 16'hFFFF, 1'b1, STS_NEW},
         '{FUNC_ACTIVATE,   8'h00, 16'h0002, 1'b1, STS_REARM},
         '{FUNC_TICK,       8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_SERVICE,    8'h00, 16'h0000, 1'b0, STS_DONE},
         '{FUNC_TICK,       8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_SERVICE,    8'h00, 16'h0000, 1'b0, STS_DONE},
         '{FUNC_ACTIVATE,   8'h3C, 16'h0001, 1'b1, STS_NEW},
         '{FUNC_TICK,       8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_TICK,       8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_SERVICE,    8'h00, 16'h0000, 1'b0, STS_DONE},
         '{FUNC_CANCEL,     8'hFF, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_ACTIVATE,   8'hC3, 16'h8000, 1'b1, STS_NEW},
         '{FUNC_CANCEL,     8'h3C, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_SERVICE,    8'h00, 16'h0000, 1'b0, STS_DONE},
         '{FUNC_CANCEL_ALL, 8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_SERVICE,    8'h00, 16'h0000, 1'b1, STS_DONE},
         '{FUNC_ACTIVATE,   8'h81, 16'h7FFF, 1'b1, STS_NEW},
         '{FUNC_CANCEL_ALL, 8'h00, 16'h0000, 1'b1, STS_DONE}
      };
      foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(0, 255));
      reset_shadow_table();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_ops[i])
         issue_op(directed_ops[i].func, directed_ops[i].event_id, directed_ops[i].interval,
                  directed_ops[i].typed, directed_ops[i].status);
      drain_results();

      // fill every slot, make all of them due at once, then overflow the table
      base_id = 8'($urandom_range(0, 239));
      for (int i = 0; i < SLOT_COUNT; i++) issue_op(FUNC_ACTIVATE, base_id + 8'(i), 16'd1);
      issue_op(FUNC_TICK, pick_id(), pick_interval());
      issue_op(FUNC_SERVICE, pick_id(), pick_interval());
      issue_op(FUNC_ACTIVATE, base_id + 8'(SLOT_COUNT), pick_interval());
      issue_op(FUNC_CANCEL_ALL, pick_id(), pick_interval());

      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         tx_calm = ($urandom_range(0, 5) == 0);
         kind    = $urandom_range(0, 9);
         if (kind <= 1) begin
            count = $urandom_range(SLOT_COUNT - 2, SLOT_COUNT + 3);
            repeat (count) issue_op(FUNC_ACTIVATE, 8'($urandom_range(0, 255)),
                                    16'($urandom_range(1, 3)));
            repeat ($urandom_range(1, 3)) issue_op(FUNC_TICK, pick_id(), pick_interval());
            issue_op(FUNC_SERVICE, pick_id(), pick_interval());
         end else if (kind <= 5) begin
            repeat ($urandom_range(4, 12)) begin
               count = $urandom_range(0, 19);
               if (count < 7) issue_op(FUNC_ACTIVATE, pick_id(), pick_interval());
               else if (count < 13) issue_op(FUNC_TICK, pick_id(), pick_interval());
               else if (count < 18) issue_op(FUNC_SERVICE, pick_id(), pick_interval());
               else issue_op(FUNC_CANCEL, pick_id(), pick_interval());
            end
         end else if (kind == 6) begin
            if ($urandom_range(0, 1) == 0) drain_results();
            issue_op(FUNC_CANCEL_ALL, pick_id(), pick_interval());
         end else if (kind <= 8) begin
            repeat ($urandom_range(1, 4)) issue_op(FUNC_TICK, pick_id(), pick_interval());
            issue_op(FUNC_SERVICE, pick_id(), pick_interval());
         end else begin
            repeat ($urandom_range(3, 8))
               issue_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)));
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d operations and %0d result transfers: %0d due events fired,",
               items_sent, results_seen, fired_seen);
      $display("%0d re-arms and %0d full-table refusals", rearm_seen, full_seen);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatching results", error_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
